// ===== hw/rtl/tlrqs_pkg.sv =====
// tlrqs_pkg: shared types, constants and codes for the ready-queue scheduler
// no dependencies
`timescale 1ns / 1ps
package tlrqs_pkg;
  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_DISPATCH = 3'd2, CMD_REQUEUE = 3'd3,
    CMD_WAKE_PID = 3'd4, CMD_WAKE_KIND = 3'd5, CMD_TICK = 3'd6, CMD_NOP = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK = 3'd0, STS_FULL = 3'd1, STS_BAD_KIND = 3'd2, STS_NOT_FOUND = 3'd3,
    STS_NONE_READY = 3'd4, STS_BUSY = 3'd5, STS_NOT_RUNNING = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    TS_READY = 2'd0, TS_WAITING = 2'd1, TS_TERM = 2'd2
  } tstate_e;

  typedef enum logic [1:0] {REG_SMALLQ = 2'd0, REG_LARGEQ = 2'd1, REG_AGE = 2'd2} reg_e;

  typedef enum logic {PH_IDLE = 1'b0, PH_EXEC = 1'b1} phase_e;

  // one table entry
  typedef struct packed {
    logic [15:0] pid;
    logic [1:0]  st;
    logic        lq;
    logic        hi;
    logic [2:0]  kind;
    logic [15:0] sleep;
    logic [31:0] wt;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        tick;
    logic        wake_pid;
    logic        wake_kind;
    logic        drop;       // shift entries above drop_idx down by one
    logic [IdxW-1:0] drop_idx;
    logic        append;
    logic [IdxW-1:0] app_idx;
    entry_t      app_entry;
    logic [15:0] pid;
    logic [2:0]  kind;
    logic [7:0]  age;
    logic [CntW-1:0] count;
  } bcast_t;

  // per-cell match flags back to the controller
  typedef struct packed {
    logic pid_hit;
    logic wait_pid_hit;
    logic rdy_hi;
    logic rdy_lo;
    logic work;
  } flags_t;
endpackage

// ===== hw/rtl/tlrqs_cell.sv =====
// tlrqs_cell: one table entry with its match logic and shift path
// depends on tlrqs_pkg
`timescale 1ns / 1ps
module tlrqs_cell (
  input  logic                       clk_i,
  input  logic [tlrqs_pkg::IdxW-1:0] idx_i,
  input  tlrqs_pkg::bcast_t          bc_i,
  input  tlrqs_pkg::entry_t          up_i,   // entry of the next cell
  output tlrqs_pkg::entry_t          ent_o,
  output tlrqs_pkg::flags_t          flg_o
);
  import tlrqs_pkg::*;

  entry_t ent_q, ent_d;
  logic   used;
  logic [32:0] wsum;

  assign used = ({1'b0, idx_i} < bc_i.count);
  assign wsum = {1'b0, ent_q.wt} + {25'd0, bc_i.age};

  // flags for the controller's oldest-first search
  always_comb begin
    flg_o.pid_hit      = used && ent_q.pid == bc_i.pid;
    flg_o.wait_pid_hit = flg_o.pid_hit && ent_q.st == TS_WAITING;
    flg_o.rdy_hi       = used && ent_q.st == TS_READY && ent_q.hi;
    flg_o.rdy_lo       = used && ent_q.st == TS_READY && !ent_q.hi;
    flg_o.work         = used && (ent_q.st == TS_READY || ent_q.st == TS_WAITING);
  end

  // next entry
  always_comb begin
    ent_d = ent_q;
    if (bc_i.tick && ent_q.st != TS_TERM) begin
      ent_d.wt = wsum[32] ? '1 : wsum[31:0];
      if (ent_q.st == TS_WAITING) begin
        if (ent_q.sleep != 16'd0) ent_d.sleep = ent_q.sleep - 16'd1;
        else ent_d.st = TS_READY;
      end
    end
    if (bc_i.wake_pid && idx_i == bc_i.drop_idx) begin
      ent_d.st = TS_READY;
      ent_d.sleep = '0;
    end
    if (bc_i.wake_kind && ent_q.kind == bc_i.kind && ent_q.st == TS_WAITING) begin
      ent_d.st = TS_READY;
      ent_d.sleep = '0;
    end
    if (bc_i.drop && idx_i >= bc_i.drop_idx) ent_d = up_i;
    if (bc_i.append && idx_i == bc_i.app_idx) ent_d = bc_i.app_entry;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
endmodule

// ===== hw/rtl/two_level_ready_queue_scheduler.sv =====
// two_level_ready_queue_scheduler: top level, command decode and cell chain
// depends on tlrqs_pkg and tlrqs_cell
//
// channel   dir  handshake       payload
// s_axis    in   tvalid/tready   tdata: command[2:0] target_pid[18:3] task_kind[21:19]
//                                high_priority[22] long_quantum[23] outcome[25:24]
//                                sleep_ticks[41:26]
// m_axis    out  tvalid/tready   tdata: status, result_pid, granted_ticks, waited_time,
//                                preempt_due, has_work, queued_count
// cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i
//
// each command is first registered; then, in the exec phase, the cell flags are gathered,
// it is applied to the chain and the result register is loaded.
// a new command is taken while idle, once the result register is free or being taken.
// reset clears the counters and running task; table contents need no clear.
`timescale 1ns / 1ps
module two_level_ready_queue_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // command, target_pid, task_kind, high_priority,
                                     // long_quantum, outcome, sleep_ticks
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // status, result_pid, granted_ticks, waited_time,
                                     // preempt_due, has_work, queued_count
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import tlrqs_pkg::*;

  localparam int unsigned N = MaxTasks;

  phase_e ph_q, ph_d;
  logic [41:0] cmd_q;
  logic [7:0]  smallq_q, largeq_q, age_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] npid_q, npid_d;
  logic        rv_q, rv_d;
  logic [15:0] rpid_q, rpid_d;
  logic [4:0]  rinfo_q, rinfo_d;
  logic [31:0] rwt_q, rwt_d;
  logic [7:0]  qleft_q, qleft_d;
  logic        ov_q;
  logic [71:0] od_q, od_d;

  bcast_t bc;
  entry_t ent [N];
  flags_t flg [N];
  logic [N-1:0] m_pid, m_wpid, m_hi, m_lo, m_work, m_work_n;

  cmd_e        cmd;
  logic [15:0] tpid, slp;
  logic [2:0]  kind;
  logic        hi, lq, kind_ok, full;
  logic [1:0]  oc;
  logic [IdxW-1:0] sel_idx;
  logic        sel_ok;
  logic [N-1:0] sel_vec;
  logic [2:0]  sts;
  logic [15:0] o_pid;
  logic [7:0]  o_grant;
  logic [31:0] o_wt;
  logic        o_pre;

  assign cmd  = cmd_e'(cmd_q[2:0]);
  assign tpid = cmd_q[18:3];
  assign kind = cmd_q[21:19];
  assign hi   = cmd_q[22];
  assign lq   = cmd_q[23];
  assign oc   = cmd_q[25:24];
  assign slp  = cmd_q[41:26];
  assign kind_ok = kind >= 3'd1 && kind <= 3'd6;
  assign full = cnt_q >= CntW'(N);

  assign s_axis_tready = ph_q == PH_IDLE && (!ov_q || m_axis_tready);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  // cell chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    entry_t up;
    if (g == N - 1) begin : g_end
      assign up = ent[g];
    end else begin : g_mid
      assign up = ent[g+1];
    end
    tlrqs_cell u_cell (
      .clk_i (clk_i), .idx_i (IdxW'(g)), .bc_i (bc), .up_i (up),
      .ent_o (ent[g]), .flg_o (flg[g])
    );
    assign m_pid[g]  = flg[g].pid_hit;
    assign m_wpid[g] = flg[g].wait_pid_hit;
    assign m_hi[g]   = flg[g].rdy_hi;
    assign m_lo[g]   = flg[g].rdy_lo;
    assign m_work[g] = flg[g].work;
  end

  // pick the vector for the oldest-first search
  always_comb begin
    sel_vec = '0;
    unique case (cmd)
      CMD_REMOVE:   sel_vec = m_pid;
      CMD_WAKE_PID: sel_vec = m_wpid;
      CMD_DISPATCH: sel_vec = (|m_hi) ? m_hi : m_lo;
      default:      sel_vec = '0;
    endcase
  end

  // lowest set bit
  always_comb begin
    sel_idx = '0;
    sel_ok  = 1'b0;
    for (int k = N - 1; k >= 0; k--) begin
      if (sel_vec[k]) begin
        sel_idx = IdxW'(k);
        sel_ok  = 1'b1;
      end
    end
  end

  // phase control
  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      PH_IDLE: if (s_axis_tvalid && s_axis_tready) ph_d = PH_EXEC;
      PH_EXEC: ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  // command execution
  always_comb begin
    cnt_d = cnt_q; npid_d = npid_q; rv_d = rv_q; rpid_d = rpid_q;
    rinfo_d = rinfo_q; rwt_d = rwt_q; qleft_d = qleft_q;
    sts = STS_OK; o_pid = '0; o_grant = '0; o_wt = '0; o_pre = 1'b0;
    bc = '0;
    bc.pid = tpid; bc.kind = kind; bc.age = age_q; bc.count = cnt_q;
    bc.drop_idx = sel_idx;
    bc.app_idx = cnt_q[IdxW-1:0];
    bc.app_entry = '0;
    m_work_n = m_work;
    if (ph_q == PH_EXEC) begin
      unique case (cmd)
        CMD_ADD: begin
          if (!kind_ok) sts = STS_BAD_KIND;
          else if (full) sts = STS_FULL;
          else begin
            npid_d = npid_q + 16'd1;
            bc.append = 1'b1;
            bc.app_entry.pid = npid_d;
            bc.app_entry.kind = kind;
            bc.app_entry.hi = hi;
            bc.app_entry.lq = lq;
            bc.app_entry.st = TS_READY;
            cnt_d = cnt_q + 1'b1;
            o_pid = npid_d;
            m_work_n = '1;
          end
        end
        CMD_REMOVE: begin
          if (rv_q) begin
            if (tpid == rpid_q) begin
              rv_d = 1'b0; qleft_d = '0;
            end else sts = STS_BUSY;
          end else if (!sel_ok) sts = STS_NOT_FOUND;
          else begin
            bc.drop = 1'b1;
            cnt_d = cnt_q - 1'b1;
            m_work_n[sel_idx] = 1'b0;
          end
        end
        CMD_DISPATCH: begin
          if (rv_q) sts = STS_BUSY;
          else if (!sel_ok) sts = STS_NONE_READY;
          else begin
            rv_d = 1'b1;
            rpid_d = ent[sel_idx].pid;
            rinfo_d = {ent[sel_idx].lq, ent[sel_idx].hi, ent[sel_idx].kind};
            rwt_d = ent[sel_idx].wt;
            qleft_d = ent[sel_idx].lq ? largeq_q : smallq_q;
            bc.drop = 1'b1;
            cnt_d = cnt_q - 1'b1;
            m_work_n[sel_idx] = 1'b0;
            o_pid = rpid_d; o_grant = qleft_d; o_wt = rwt_d;
          end
        end
        CMD_REQUEUE: begin
          if (!rv_q) sts = STS_NOT_RUNNING;
          else if (full) sts = STS_FULL;
          else begin
            bc.append = 1'b1;
            bc.app_entry.pid = rpid_q;
            bc.app_entry.kind = rinfo_q[2:0];
            bc.app_entry.hi = rinfo_q[3];
            bc.app_entry.lq = rinfo_q[4];
            bc.app_entry.st = (oc == 2'd0) ? TS_READY :
                              (oc == 2'd1) ? TS_WAITING : TS_TERM;
            bc.app_entry.sleep = (oc == 2'd1) ? slp : 16'd0;
            bc.app_entry.wt = rwt_q;
            cnt_d = cnt_q + 1'b1;
            rv_d = 1'b0; qleft_d = '0;
            if (oc <= 2'd1) m_work_n = '1;
          end
        end
        CMD_WAKE_PID: begin
          if (!sel_ok) sts = STS_NOT_FOUND;
          else bc.wake_pid = 1'b1;
        end
        CMD_WAKE_KIND: begin
          if (!kind_ok) sts = STS_BAD_KIND;
          else bc.wake_kind = 1'b1;
        end
        CMD_TICK: begin
          bc.tick = 1'b1;
          if (rv_q) begin
            qleft_d = (qleft_q != 8'd0) ? qleft_q - 8'd1 : 8'd0;
            o_pre = qleft_d == 8'd0;
          end
        end
        default: sts = STS_OK;
      endcase
    end
    od_d = {6'd0, cnt_d, |m_work_n, o_pre, o_wt, o_grant, o_pid, sts};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; ov_q <= 1'b0;
      cnt_q <= '0; npid_q <= '0; rv_q <= 1'b0; rpid_q <= '0;
      rinfo_q <= '0; rwt_q <= '0; qleft_q <= '0;
      smallq_q <= 8'd1; largeq_q <= 8'd2; age_q <= 8'd10;
    end else begin
      ph_q <= ph_d;
      cnt_q <= cnt_d; npid_q <= npid_d; rv_q <= rv_d; rpid_q <= rpid_d;
      rinfo_q <= rinfo_d; rwt_q <= rwt_d; qleft_q <= qleft_d;
      if (ph_q == PH_EXEC) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SMALLQ: smallq_q <= cfg_data_i;
          REG_LARGEQ: largeq_q <= cfg_data_i;
          REG_AGE:    age_q <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) cmd_q <= s_axis_tdata[41:0];
    if (ph_q == PH_EXEC) od_q <= od_d;
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(N)) else $error("table count out of range");
  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_EXEC |=> ph_q == PH_IDLE && ov_q) else $error("result not loaded");
  a_no_take_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_EXEC |-> !s_axis_tready) else $error("accepted while busy");
endmodule

// ===== test/tb_sched_checker.sv =====
// tb_sched_checker: watches the command and result streams of the scheduler,
// predicts each result word and compares it whole, printing fields on a mismatch; depends on tlrqs_pkg
`timescale 1ns / 1ps
module tb_sched_checker
  import tlrqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct packed {
    logic [4:0]  count;
    logic        work;
    logic        preempt;
    logic [31:0] waited;
    logic [7:0]  grant;
    logic [15:0] pid;
    logic [2:0]  status;
  } sched_result_t;

  typedef struct {
    logic [15:0] pid;
    logic [2:0]  kind;
    logic        hi;
    logic        lq;
    tstate_e     st;
    logic [15:0] sleep;
    logic [31:0] wt;
  } task_t;

  // model state
  logic [7:0]  quant_small, quant_large, age_amt;
  task_t       tasks[$];
  logic [15:0] pid_ctr;
  logic        run_valid;
  task_t       run_task;
  logic [7:0]  quant_left;
  sched_result_t expected_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  function automatic int find_ready(logic want_hi);
    foreach (tasks[i])
      if (tasks[i].st == TS_READY && tasks[i].hi == want_hi) return i;
    return -1;
  endfunction

  task automatic schedule_command(input logic [47:0] w);
    cmd_e          cmd;
    logic [15:0]   tpid;
    logic [2:0]    kind;
    logic [1:0]    oc;
    task_t         t;
    sched_result_t r;
    int            f;
    logic          kind_ok;
    cmd = cmd_e'(w[2:0]);
    tpid = w[18:3];
    kind = w[21:19];
    oc = w[25:24];
    r = '0;
    kind_ok = kind >= 1 && kind <= 6;
    case (cmd)
      CMD_ADD: begin
        if (!kind_ok) r.status = STS_BAD_KIND;
        else if (tasks.size() >= MaxTasks) r.status = STS_FULL;
        else begin
          pid_ctr = pid_ctr + 1;
          t.pid = pid_ctr; t.kind = kind; t.hi = w[22]; t.lq = w[23];
          t.st = TS_READY; t.sleep = 0; t.wt = 0;
          tasks.push_back(t);
          r.pid = pid_ctr;
        end
      end
      CMD_REMOVE: begin
        if (run_valid) begin
          if (tpid == run_task.pid) begin
            run_valid = 0; quant_left = 0;
          end else r.status = STS_BUSY;
        end else begin
          r.status = STS_NOT_FOUND;
          f = -1;
          foreach (tasks[i]) if (f < 0 && tasks[i].pid == tpid) f = i;
          if (f >= 0) begin
            tasks.delete(f); r.status = STS_OK;
          end
        end
      end
      CMD_DISPATCH: begin
        if (run_valid) r.status = STS_BUSY;
        else begin
          f = find_ready(1'b1);
          if (f < 0) f = find_ready(1'b0);
          if (f < 0) r.status = STS_NONE_READY;
          else begin
            run_task = tasks[f];
            tasks.delete(f);
            run_valid = 1;
            quant_left = run_task.lq ? quant_large : quant_small;
            r.pid = run_task.pid; r.grant = quant_left; r.waited = run_task.wt;
          end
        end
      end
      CMD_REQUEUE: begin
        if (!run_valid) r.status = STS_NOT_RUNNING;
        else if (tasks.size() >= MaxTasks) r.status = STS_FULL;
        else begin
          t = run_task;
          t.st = (oc == 0) ? TS_READY : (oc == 1) ? TS_WAITING : TS_TERM;
          t.sleep = (t.st == TS_WAITING) ? w[41:26] : 16'd0;
          tasks.push_back(t);
          run_valid = 0; quant_left = 0;
        end
      end
      CMD_WAKE_PID: begin
        r.status = STS_NOT_FOUND;
        foreach (tasks[i])
          if (r.status != STS_OK && tasks[i].pid == tpid && tasks[i].st == TS_WAITING) begin
            tasks[i].st = TS_READY; tasks[i].sleep = 0; r.status = STS_OK;
          end
      end
      CMD_WAKE_KIND: begin
        if (!kind_ok) r.status = STS_BAD_KIND;
        else
          foreach (tasks[i])
            if (tasks[i].kind == kind && tasks[i].st == TS_WAITING) begin
              tasks[i].st = TS_READY; tasks[i].sleep = 0;
            end
      end
      CMD_TICK: begin
        foreach (tasks[i]) begin
          if (tasks[i].st != TS_TERM) begin
            if (tasks[i].wt > 32'hFFFF_FFFF - age_amt) tasks[i].wt = 32'hFFFF_FFFF;
            else tasks[i].wt = tasks[i].wt + age_amt;
            if (tasks[i].st == TS_WAITING) begin
              if (tasks[i].sleep != 0) tasks[i].sleep = tasks[i].sleep - 1;
              else tasks[i].st = TS_READY;
            end
          end
        end
        if (run_valid) begin
          if (quant_left > 0) quant_left = quant_left - 1;
          if (quant_left == 0) r.preempt = 1;
        end
      end
      default: ;
    endcase
    foreach (tasks[i]) if (tasks[i].st != TS_TERM) r.work = 1;
    r.count = 5'(tasks.size());
    expected_q.push_back(r);
  endtask

  // config, command and result tracking
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t got, want;
    if (!rst_ni) begin
      quant_small = 1; quant_large = 2; age_amt = 10;
      tasks.delete(); expected_q.delete();
      pid_ctr = 0; run_valid = 0; quant_left = 0; fails = 0;
    end else begin
      if (cfg_we_i)
        case (reg_e'(cfg_idx_i))
          REG_SMALLQ: quant_small = cfg_data_i;
          REG_LARGEQ: quant_large = cfg_data_i;
          REG_AGE:    age_amt = cfg_data_i;
          default: ;
        endcase
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[65:0];
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata[71:66] !== 6'd0) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: exp sts=%0d pid=%0d gr=%0d wt=%0d pe=%0b wk=%0b cnt=%0d",
                       want.status, want.pid, want.grant, want.waited, want.preempt,
                       want.work, want.count);
              $display("          act sts=%0d pid=%0d gr=%0d wt=%0d pe=%0b wk=%0b cnt=%0d",
                       got.status, got.pid, got.grant, got.waited, got.preempt,
                       got.work, got.count);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) schedule_command(s_axis_tdata);
    end
  end
endmodule

// ===== test/tb_top.sv =====
// tb_top: stimulus and verdict for the ready-queue scheduler
// depends on tlrqs_pkg, two_level_ready_queue_scheduler and tb_sched_checker
`timescale 1ns / 1ps
module tb_top;
  import tlrqs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  int          fail_count, pending, cycle_cnt;
  int          send_idle_pct, stall_pct;
  logic [15:0] recent_pid;

  two_level_ready_queue_scheduler dut (.*);

  tb_sched_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // send one command word, with random leading idle; valid stays up until
  // the next idle cycle or drain
  task automatic send_word(input cmd_e cmd, input logic [15:0] tpid, input logic [2:0] kind,
                           input logic hi, input logic lq, input logic [1:0] oc,
                           input logic [15:0] slp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, slp, oc, lq, hi, kind, tpid, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random command, weighted toward well-formed schedules
  task automatic send_random();
    int   p;
    cmd_e c;
    logic [15:0] tp;
    p = $urandom_range(99);
    if (p < 20) c = CMD_ADD;
    else if (p < 28) c = CMD_REMOVE;
    else if (p < 46) c = CMD_DISPATCH;
    else if (p < 62) c = CMD_REQUEUE;
    else if (p < 68) c = CMD_WAKE_PID;
    else if (p < 72) c = CMD_WAKE_KIND;
    else if (p < 98) c = CMD_TICK;
    else c = CMD_NOP;
    tp = ($urandom_range(3) == 0) ? 16'($urandom) : recent_pid - 16'($urandom_range(6));
    send_word(c, tp, ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(6, 1)),
              1'($urandom), 1'($urandom), 2'($urandom_range(9) == 0 ? 3 : $urandom_range(2)),
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
    if (c == CMD_ADD) recent_pid = recent_pid + 1;
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    cycle_cnt = 0;
    recent_pid = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edge kinds, empty table cases, full table, sleeps and wakes
    send_word(CMD_DISPATCH, 0, 0, 0, 0, 0, 0);
    send_word(CMD_REQUEUE, 0, 0, 0, 0, 0, 0);
    send_word(CMD_REMOVE, 16'hFFFF, 0, 0, 0, 0, 0);
    send_word(CMD_ADD, 0, 0, 1, 1, 0, 0);
    send_word(CMD_ADD, 0, 7, 1, 1, 0, 0);
    send_word(CMD_WAKE_KIND, 0, 7, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_word(CMD_ADD, 0, 3'(1 + i % 6), 1'(i[1]), 1'(i[0]), 0, 0);
    send_word(CMD_DISPATCH, 0, 0, 0, 0, 0, 0);
    send_word(CMD_DISPATCH, 0, 0, 0, 0, 0, 0);
    send_word(CMD_REMOVE, 16'd5, 0, 0, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send_word(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send_word(CMD_ADD, 0, 6, 0, 0, 0, 0);
    send_word(CMD_REQUEUE, 0, 0, 0, 0, 1, 16'hFFFF);
    send_word(CMD_REMOVE, 16'd1, 0, 0, 0, 0, 0);
    send_word(CMD_REQUEUE, 0, 0, 0, 0, 1, 16'hFFFF);
    send_word(CMD_WAKE_PID, 16'd3, 0, 0, 0, 0, 0);
    send_word(CMD_WAKE_PID, 16'd3, 0, 0, 0, 0, 0);
    send_word(CMD_NOP, 16'hFFFF, 7, 1, 1, 3, 16'hFFFF);
    drain();

    // random phases: configs at extremes and random, idling patterns varied
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_SMALLQ, (ph == 0) ? 8'd1 : (ph == 1) ? 8'd255 : 8'($urandom_range(1, 6)));
      write_reg(REG_LARGEQ, (ph == 0) ? 8'd255 : (ph == 1) ? 8'd1 : 8'($urandom_range(1, 9)));
      write_reg(REG_AGE, (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom));
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 67 : 37) : 0;
      stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 2 ? 67 : 37) : 0;
      // random commands, with a drain partway through
      for (int i = 0; i < 250; i++) begin
        send_random();
        if (i == 120) drain();
      end
      drain();
    end

    // set the largest aging step and drain before the verdict
    write_reg(REG_AGE, 8'd255);
    send_idle_pct = 0;
    stall_pct = 0;
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/tlrqs_pkg.sv
hw/rtl/tlrqs_cell.sv
hw/rtl/two_level_ready_queue_scheduler.sv
test/tb_sched_checker.sv
test/tb_top.sv
